### design/plb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants of the price level book
// Field widths, register indexes and the controller/datapath command words.
// ----------------------------------------------------------------------------
package plb_pkg;

   localparam int PRICE_W     = 32;
   localparam int TOTAL_W     = 40;
   localparam int QTY_W       = 32;
   localparam int LEVEL_IDX_W = 10;
   localparam int TICK_W      = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic REG_LOWER_PRICE = 1'b0;
   localparam logic REG_TICK_SIZE   = 1'b1;

   localparam logic [PRICE_W-1:0] LOWER_PRICE_RESET = '0;
   localparam logic [TICK_W-1:0]  TICK_SIZE_RESET   = 16'd100;

   typedef struct packed {
      logic clr;       // write one clearing entry
      logic load_req;  // capture the request word
      logic rd_cur;    // read address from walk cursor, else from level
      logic eval;      // volume update, link decision
      logic walk_ev;   // evaluate one list step
      logic w1;        // write links of the level itself
      logic w2;        // write neighbor links / list head
      logic mul;       // price products
      logic fin;       // load result word
   } plb_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic act_link;
      logic act_unlink;
      logic head_case;
      logic walk_stop;
   } plb_sts_type;

endpackage
`default_nettype wire

### design/plb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plb_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface plb_req_if import plb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic                   is_buy;
   logic [LEVEL_IDX_W-1:0] level_index;
   logic [QTY_W-1:0]       quantity;

   modport source (output valid, req_type, is_buy, level_index, quantity, input ready);
   modport sink   (input valid, req_type, is_buy, level_index, quantity, output ready);
endinterface

interface plb_rsp_if import plb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] best_bid_price;
   logic [PRICE_W-1:0] best_ask_price;
   logic [TOTAL_W-1:0] level_total;
   logic               underflow_error;

   modport source (output valid, best_bid_price, best_ask_price, level_total,
                   underflow_error, input ready);
   modport sink   (input valid, best_bid_price, best_ask_price, level_total,
                   underflow_error, output ready);
endinterface
`default_nettype wire

### design/plb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plb_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/plb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plb_ctrl: sequencer of the price level book
// Clearing pass, per-request read/update/link steps and response handoff.
// ----------------------------------------------------------------------------
module plb_ctrl import plb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   output plb_cmd_type      cmd,
   input  wire plb_sts_type sts,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready
);
   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_READ    = 10'b0000000100,
      ST_EVAL    = 10'b0000001000,
      ST_WALK_RD = 10'b0000010000,
      ST_WALK_EV = 10'b0000100000,
      ST_W1      = 10'b0001000000,
      ST_W2      = 10'b0010000000,
      ST_MUL     = 10'b0100000000,
      ST_FIN     = 10'b1000000000
   } plb_state_type;

   plb_state_type state_ff, state_in;
   logic          out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.act_unlink)    state_in = ST_W2;
            else if (sts.act_link) state_in = sts.head_case ? ST_W1 : ST_WALK_RD;
            else                   state_in = ST_MUL;
         end
         ST_WALK_RD: begin
            cmd.rd_cur = 1'b1;
            state_in   = ST_WALK_EV;
         end
         ST_WALK_EV: begin
            cmd.rd_cur  = 1'b1;
            cmd.walk_ev = 1'b1;
            state_in    = sts.walk_stop ? ST_W1 : ST_WALK_RD;
         end
         ST_W1: begin
            cmd.w1   = 1'b1;
            state_in = ST_W2;
         end
         ST_W2: begin
            cmd.w2   = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.fin)        out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule
`default_nettype wire

### design/plb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plb_dp: datapath of the price level book
// Volume and link memories of both sides, list heads, walk cursor, pricing.
// ----------------------------------------------------------------------------
module plb_dp import plb_pkg::*; #(
   parameter int LEVEL_COUNT  = 1024,
   parameter int VOLUME_WIDTH = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire plb_cmd_type            cmd,
   output plb_sts_type                 sts,
   input  wire logic                   req_type,
   input  wire logic                   is_buy,
   input  wire logic [LEVEL_IDX_W-1:0] level_index,
   input  wire logic [QTY_W-1:0]       quantity,
   input  wire logic [PRICE_W-1:0]     lower_price,
   input  wire logic [TICK_W-1:0]      tick_size,
   output logic      [PRICE_W-1:0]     best_bid_price,
   output logic      [PRICE_W-1:0]     best_ask_price,
   output logic      [TOTAL_W-1:0]     level_total,
   output logic                        underflow_error
);
   localparam int IW    = $clog2(LEVEL_COUNT);
   localparam int LW    = IW + 1;           // link: MSB set means null
   localparam int AW    = IW + 1;           // memory address {side, level}
   localparam int DEPTH = 2 ** AW;
   localparam int SW    = ((VOLUME_WIDTH > QTY_W) ? VOLUME_WIDTH : QTY_W) + 1;
   localparam int PW    = IW + TICK_W;
   localparam int XW    = PRICE_W + 1;
   localparam logic [LW-1:0] NULL_LINK = {1'b1, {IW{1'b0}}};
   localparam logic [VOLUME_WIDTH-1:0] VOL_MAX = '1;

   function automatic logic ranks_before(input logic buy, input logic [IW-1:0] a,
                                         input logic [IW-1:0] b);
      return buy ? (a > b) : (a < b);
   endfunction

   // request word
   logic                    sub_ff, buy_ff, oor_ff;
   logic [IW-1:0]           lv_ff;
   logic [QTY_W-1:0]        qty_ff;
   // working registers
   logic [AW-1:0]           clr_ff;
   logic [VOLUME_WIDTH-1:0] vol_res_ff;
   logic                    err_ff, linking_ff;
   logic [LW-1:0]           cur_ff, after_ff, bid_head_ff, ask_head_ff;
   logic [PW-1:0]           prod_bid_ff, prod_ask_ff;
   logic [PRICE_W-1:0]      bid_price_ff, ask_price_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic                    uerr_ff;

   // memory ports
   logic [AW-1:0]           rd_addr;
   logic [VOLUME_WIDTH-1:0] vol_rd;
   logic [LW-1:0]           prev_rd, next_rd;
   logic                    vol_we, prev_we, next_we;
   logic [AW-1:0]           vol_wa, prev_wa, next_wa;
   logic [VOLUME_WIDTH-1:0] vol_wd;
   logic [LW-1:0]           prev_wd, next_wd;

   // update logic
   logic [SW-1:0]           v_ext, q_ext, sum;
   logic [VOLUME_WIDTH-1:0] add_val, vol_new;
   logic                    under, do_link, do_unlink;
   logic [LW-1:0]           head, lv_link;
   logic [XW-1:0]           bid_sum, ask_sum;

   assign rd_addr = {buy_ff, cmd.rd_cur ? cur_ff[IW-1:0] : lv_ff};
   assign lv_link = {1'b0, lv_ff};
   assign head    = buy_ff ? bid_head_ff : ask_head_ff;

   always_comb begin
      v_ext     = SW'(vol_rd);
      q_ext     = SW'(qty_ff);
      sum       = v_ext + q_ext;
      add_val   = (sum > SW'(VOL_MAX)) ? VOL_MAX : sum[VOLUME_WIDTH-1:0];
      under     = q_ext > v_ext;
      if (!sub_ff)    vol_new = add_val;
      else if (under) vol_new = vol_rd;
      else            vol_new = VOLUME_WIDTH'(v_ext - q_ext);
      do_link   = !oor_ff && !sub_ff && (vol_rd == '0) && (vol_new != '0);
      do_unlink = !oor_ff && sub_ff && !under && (vol_rd != '0) && (vol_new == '0);
   end

   assign sts.clr_done   = &clr_ff;
   assign sts.act_link   = do_link;
   assign sts.act_unlink = do_unlink;
   assign sts.head_case  = head[IW] || ranks_before(buy_ff, lv_ff, head[IW-1:0]);
   assign sts.walk_stop  = next_rd[IW] || !ranks_before(buy_ff, next_rd[IW-1:0], lv_ff);

   // write ports
   always_comb begin
      vol_we  = 1'b0;
      vol_wa  = {buy_ff, lv_ff};
      vol_wd  = vol_new;
      prev_we = 1'b0;
      prev_wa = {buy_ff, lv_ff};
      prev_wd = cur_ff;
      next_we = 1'b0;
      next_wa = {buy_ff, lv_ff};
      next_wd = after_ff;
      priority if (cmd.clr) begin
         vol_we  = 1'b1;
         vol_wa  = clr_ff;
         vol_wd  = '0;
         prev_we = 1'b1;
         prev_wa = clr_ff;
         prev_wd = NULL_LINK;
         next_we = 1'b1;
         next_wa = clr_ff;
         next_wd = NULL_LINK;
      end else if (cmd.eval) begin
         vol_we = !oor_ff;
      end else if (cmd.w1) begin
         prev_we = 1'b1;
         next_we = 1'b1;
      end else if (cmd.w2) begin
         next_we = !cur_ff[IW];
         next_wa = {buy_ff, cur_ff[IW-1:0]};
         next_wd = linking_ff ? lv_link : after_ff;
         prev_we = !after_ff[IW];
         prev_wa = {buy_ff, after_ff[IW-1:0]};
         prev_wd = linking_ff ? lv_link : cur_ff;
      end
   end

   plb_ram #(.WIDTH(VOLUME_WIDTH), .DEPTH(DEPTH)) u_vol_ram (
      .clock, .wr_en(vol_we), .wr_addr(vol_wa), .wr_data(vol_wd),
      .rd_addr, .rd_data(vol_rd)
   );
   plb_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_prev_ram (
      .clock, .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr, .rd_data(prev_rd)
   );
   plb_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next_ram (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr, .rd_data(next_rd)
   );

   assign bid_sum = XW'(lower_price) + XW'(prod_bid_ff);
   assign ask_sum = XW'(lower_price) + XW'(prod_ask_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         bid_head_ff <= NULL_LINK;
         ask_head_ff <= NULL_LINK;
      end else begin
         if (cmd.clr) clr_ff <= clr_ff + 1'b1;
         if (cmd.w2 && cur_ff[IW]) begin
            // level becomes or leaves the list head
            if (buy_ff) bid_head_ff <= linking_ff ? lv_link : after_ff;
            else        ask_head_ff <= linking_ff ? lv_link : after_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sub_ff <= req_type;
         buy_ff <= is_buy;
         lv_ff  <= IW'(level_index);
         qty_ff <= quantity;
         oor_ff <= 32'(level_index) >= 32'(LEVEL_COUNT);
      end
      if (cmd.eval) begin
         vol_res_ff <= oor_ff ? '0 : vol_new;
         err_ff     <= !oor_ff && sub_ff && under;
         linking_ff <= do_link;
         if (do_unlink) begin
            cur_ff   <= prev_rd;
            after_ff <= next_rd;
         end else if (sts.head_case) begin
            cur_ff   <= NULL_LINK;
            after_ff <= head;
         end else begin
            cur_ff   <= head;
            after_ff <= NULL_LINK;
         end
      end
      if (cmd.walk_ev) begin
         if (sts.walk_stop) after_ff <= next_rd;
         else               cur_ff   <= next_rd;
      end
      if (cmd.mul) begin
         prod_bid_ff <= PW'(bid_head_ff[IW-1:0]) * PW'(tick_size);
         prod_ask_ff <= PW'(ask_head_ff[IW-1:0]) * PW'(tick_size);
      end
      if (cmd.fin) begin
         if (bid_head_ff[IW])  bid_price_ff <= '0;
         else if (bid_sum[XW-1]) bid_price_ff <= '1;
         else                  bid_price_ff <= bid_sum[PRICE_W-1:0];
         if (ask_head_ff[IW])  ask_price_ff <= '0;
         else if (ask_sum[XW-1]) ask_price_ff <= '1;
         else                  ask_price_ff <= ask_sum[PRICE_W-1:0];
         total_ff <= TOTAL_W'(vol_res_ff);
         uerr_ff  <= err_ff;
      end
   end

   assign best_bid_price  = bid_price_ff;
   assign best_ask_price  = ask_price_ff;
   assign level_total     = total_ff;
   assign underflow_error = uerr_ff;
endmodule
`default_nettype wire

### design/price_level_book_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// price_level_book_top: aggregated order book price levels, buy and sell
// Adds or removes volume at one level per request and tracks best bid/ask.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one request word (req_type, is_buy, level_index, quantity)
//   with valid/ready. rsp_if returns one response word per request: both best
//   prices, the new level volume and the underflow flag.
//   csr_* is an APB-style port: lower_price at 0x0, tick_size at 0x4.
// Sequence:
//   Requests are processed one at a time. A request that leaves the sorted
//   list alone goes through READ, EVAL, MUL and FIN, and the next request can
//   be taken once its response word is valid; an unlink adds W2, an insert at
//   the list head adds W1 and W2, and an insert deeper in the list also adds
//   WALK_RD and WALK_EV per level walked, since next-link reads are registered.
// Reset:
//   After reset a clearing pass writes all 2*2**clog2(LEVEL_COUNT) memory
//   entries, one per cycle; req_if.ready stays low until it ends.
// Backpressure:
//   The response sits in an output register; while rsp_if.ready is low the
//   next request is still accepted and worked, and waits only at handoff.
// ----------------------------------------------------------------------------
module price_level_book_top import plb_pkg::*; #(
   parameter int LEVEL_COUNT  = 1024,
   parameter int VOLUME_WIDTH = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   plb_req_if.sink                    req_if,
   plb_rsp_if.source                  rsp_if,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   logic [PRICE_W-1:0] lower_price_ff;
   logic [TICK_W-1:0]  tick_size_ff;
   logic               csr_wr;
   plb_cmd_type        cmd;
   plb_sts_type        sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TICK_SIZE) ? CSR_DATA_W'(tick_size_ff)
                                                       : CSR_DATA_W'(lower_price_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_price_ff <= LOWER_PRICE_RESET;
         tick_size_ff   <= TICK_SIZE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_LOWER_PRICE: lower_price_ff <= csr_pwdata[PRICE_W-1:0];
            REG_TICK_SIZE:   tick_size_ff   <= csr_pwdata[TICK_W-1:0];
            default:         ;
         endcase
      end
   end

   plb_ctrl u_ctrl (
      .clock, .reset, .cmd, .sts,
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready)
   );

   plb_dp #(.LEVEL_COUNT(LEVEL_COUNT), .VOLUME_WIDTH(VOLUME_WIDTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_type(req_if.req_type), .is_buy(req_if.is_buy),
      .level_index(req_if.level_index), .quantity(req_if.quantity),
      .lower_price(lower_price_ff), .tick_size(tick_size_ff),
      .best_bid_price(rsp_if.best_bid_price), .best_ask_price(rsp_if.best_ask_price),
      .level_total(rsp_if.level_total), .underflow_error(rsp_if.underflow_error)
   );

   // clearing pass blocks intake
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_if.ready)
      else $error("request accepted during clearing pass");

   // one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("second request accepted back to back");

   // memories are not swept while a request can be taken
   a_clr_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !req_if.ready && !cmd.fin)
      else $error("clearing overlaps request handling");
endmodule
`default_nettype wire
